// ===== rtl/core/i2csr_pkg.sv =====
// shared types, codes and constants for the i2c sensor measurement reader
// no dependencies; every other file in rtl/core refers to this package by scoped name

package i2csr_pkg;

	// field widths
	localparam int KIND_W      = 2;
	localparam int ADDR_W      = 7;
	localparam int CMD_W       = 16;
	localparam int RAW_W       = 16;
	localparam int TEMP_W      = 15;
	localparam int HUM_W       = 14;
	localparam int CFG_INDEX_W = 2;

	// parameter defaults
	localparam int READ_BYTES_DEF = 6;
	localparam int WAIT_WIDTH_DEF = 20;

	// register reset values
	localparam logic [ADDR_W-1:0] RESET_DEVICE_ADDRESS = 7'h44;
	localparam logic [CMD_W-1:0]  RESET_MEASURE_COMMAND = 16'h2130;
	localparam int                RESET_WAIT_TICKS = 5000;

	// break transaction
	localparam logic [ADDR_W-1:0] BREAK_ADDR = 7'h44;
	localparam logic [CMD_W-1:0]  BREAK_CMD  = 16'h3093;

	// conversion constants, centi-units over full scale 65535
	localparam int TEMP_SCALE  = 17500;
	localparam int TEMP_OFFSET = 4500;
	localparam int HUM_SCALE   = 10000;
	localparam int TEMP_PROD_W = 31;
	localparam int HUM_PROD_W  = 30;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BREAK   = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_COMMAND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TICKS      = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_TXBIT  = 3'd1,
		PH_TXACK  = 3'd2,
		PH_WAIT   = 3'd3,
		PH_RSTART = 3'd4,
		PH_RXBIT  = 3'd5,
		PH_RXACK  = 3'd6,
		PH_STOP   = 3'd7
	} phase_t;

	// per-tick line and status flags
	typedef struct packed {
		logic scl;
		logic sda_pull_low;
		logic busy;
		logic done;
		logic nack_error;
	} flags_t;

	// what one tick of the bus engine produces
	typedef struct packed {
		flags_t           flags;
		logic [RAW_W-1:0] temp_raw;
		logic [RAW_W-1:0] hum_raw;
	} step_t;

endpackage

// ===== rtl/core/i2csr_if.sv =====
// channel interfaces of the i2c sensor measurement reader: tick input and result output
// depends on i2csr_pkg for field widths

interface i2csr_tick_if;
	logic                          valid;
	logic                          ready;
	logic [i2csr_pkg::KIND_W-1:0]  kind;
	logic                          sda_in;

	modport source (output valid, kind, sda_in, input ready);
	modport sink (input valid, kind, sda_in, output ready);
endinterface

interface i2csr_result_if;
	logic                                valid;
	logic                                ready;
	logic                                scl;
	logic                                sda_pull_low;
	logic                                busy_res;
	logic                                done_res;
	logic                                nack_error;
	logic signed [i2csr_pkg::TEMP_W-1:0] temperature_centi;
	logic [i2csr_pkg::HUM_W-1:0]         humidity_centi;

	modport source (output valid, scl, sda_pull_low, busy_res, done_res, nack_error,
		temperature_centi, humidity_centi, input ready);
	modport sink (input valid, scl, sda_pull_low, busy_res, done_res, nack_error,
		temperature_centi, humidity_centi, output ready);
endinterface

// ===== rtl/core/i2csr_engine.sv =====
// bit-level i2c master engine: transaction state and per-tick line levels
// depends on i2csr_pkg (phase_t, step_t, codes and constants)

module i2csr_engine #(
	parameter int READ_BYTES = i2csr_pkg::READ_BYTES_DEF,
	parameter int WAIT_WIDTH = i2csr_pkg::WAIT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [i2csr_pkg::KIND_W-1:0]       kind,
	input  logic                               sda_in,
	input  logic [i2csr_pkg::ADDR_W-1:0]       device_address,
	input  logic [i2csr_pkg::CMD_W-1:0]        measure_command,
	input  logic [WAIT_WIDTH-1:0]              wait_ticks,
	output i2csr_pkg::step_t                   res
);

	localparam logic [2:0] LAST_BYTE = 3'(READ_BYTES - 1);

	i2csr_pkg::phase_t                phase_q, phase_n;
	logic                             brk_q, brk_n;
	logic [1:0]                       sub_q, sub_n;
	logic [2:0]                       bit_q, bit_n;
	logic [2:0]                       byte_q, byte_n;
	logic [7:0]                       shift_q, shift_n;
	logic [WAIT_WIDTH-1:0]            delay_q, delay_n;
	logic [i2csr_pkg::RAW_W-1:0]      temp_q, temp_n;
	logic [i2csr_pkg::RAW_W-1:0]      hum_q, hum_n;
	logic [7:0]                       high_q, high_n;
	logic                             scl_q, sdah_q;
	logic                             err_q, err_n;

	logic       scl_o, sdah_o, done_o;
	logic       start_req;
	logic       last_sub;
	logic [7:0] rx_byte;
	logic [i2csr_pkg::CMD_W-1:0] cmd;

	assign start_req = (kind == i2csr_pkg::KIND_MEASURE) || (kind == i2csr_pkg::KIND_BREAK);
	assign last_sub  = (sub_q >= 2'd2);
	assign rx_byte   = {shift_q[6:0], sda_in};
	assign cmd       = brk_q ? i2csr_pkg::BREAK_CMD : measure_command;

	// line levels for this tick
	always_comb begin
		scl_o  = scl_q;
		sdah_o = sdah_q;
		done_o = 1'b0;
		unique case (phase_q)
			i2csr_pkg::PH_IDLE: begin
				scl_o  = 1'b1;
				sdah_o = !start_req;
			end
			i2csr_pkg::PH_TXBIT, i2csr_pkg::PH_TXACK,
			i2csr_pkg::PH_RXBIT, i2csr_pkg::PH_RXACK: begin
				if (sub_q == 2'd0) begin
					scl_o = 1'b0;
				end else begin
					scl_o = last_sub;
					if (phase_q == i2csr_pkg::PH_TXBIT) begin
						sdah_o = shift_q[7];
					end else if (phase_q == i2csr_pkg::PH_RXACK) begin
						sdah_o = (byte_q >= LAST_BYTE);
					end else begin
						sdah_o = 1'b1;
					end
				end
			end
			i2csr_pkg::PH_WAIT: begin
				scl_o  = 1'b0;
				sdah_o = 1'b1;
			end
			i2csr_pkg::PH_RSTART: begin
				unique case (sub_q)
					2'd0: begin
						scl_o  = 1'b0;
						sdah_o = 1'b1;
					end
					2'd1: begin
						scl_o  = 1'b1;
						sdah_o = 1'b1;
					end
					default: begin
						scl_o  = 1'b1;
						sdah_o = 1'b0;
					end
				endcase
			end
			i2csr_pkg::PH_STOP: begin
				unique case (sub_q)
					2'd0: scl_o = 1'b0;
					2'd1: begin
						scl_o  = 1'b0;
						sdah_o = 1'b0;
					end
					2'd2: begin
						scl_o  = 1'b1;
						sdah_o = 1'b0;
					end
					default: begin
						scl_o  = 1'b1;
						sdah_o = 1'b1;
						done_o = 1'b1;
					end
				endcase
			end
		endcase
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		brk_n   = brk_q;
		sub_n   = sub_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		delay_n = delay_q;
		temp_n  = temp_q;
		hum_n   = hum_q;
		high_n  = high_q;
		err_n   = err_q;
		unique case (phase_q)
			i2csr_pkg::PH_IDLE: begin
				if (start_req) begin
					brk_n   = (kind == i2csr_pkg::KIND_BREAK);
					err_n   = 1'b0;
					byte_n  = 3'd0;
					sub_n   = 2'd0;
					bit_n   = 3'd0;
					shift_n = (kind == i2csr_pkg::KIND_BREAK) ?
						{i2csr_pkg::BREAK_ADDR, 1'b0} : {device_address, 1'b0};
					phase_n = i2csr_pkg::PH_TXBIT;
				end
			end
			i2csr_pkg::PH_TXBIT, i2csr_pkg::PH_TXACK,
			i2csr_pkg::PH_RXBIT, i2csr_pkg::PH_RXACK: begin
				if (!last_sub) begin
					sub_n = sub_q + 2'd1;
				end else begin
					sub_n = 2'd0;
					unique case (phase_q)
						i2csr_pkg::PH_TXBIT: begin
							shift_n = {shift_q[6:0], 1'b0};
							if (bit_q == 3'd7) begin
								bit_n   = 3'd0;
								phase_n = i2csr_pkg::PH_TXACK;
							end else begin
								bit_n = bit_q + 3'd1;
							end
						end
						i2csr_pkg::PH_TXACK: begin
							if (sda_in) begin
								// missing acknowledge aborts into stop
								err_n   = 1'b1;
								phase_n = i2csr_pkg::PH_STOP;
							end else begin
								unique case (byte_q)
									3'd0: begin
										byte_n  = 3'd1;
										shift_n = cmd[15:8];
										bit_n   = 3'd0;
										phase_n = i2csr_pkg::PH_TXBIT;
									end
									3'd1: begin
										byte_n  = 3'd2;
										shift_n = cmd[7:0];
										bit_n   = 3'd0;
										phase_n = i2csr_pkg::PH_TXBIT;
									end
									3'd2: begin
										if (brk_q) begin
											phase_n = i2csr_pkg::PH_STOP;
										end else begin
											delay_n = wait_ticks;
											phase_n = (wait_ticks == '0) ?
												i2csr_pkg::PH_RSTART : i2csr_pkg::PH_WAIT;
										end
									end
									default: begin
										byte_n  = 3'd0;
										bit_n   = 3'd0;
										shift_n = 8'd0;
										phase_n = i2csr_pkg::PH_RXBIT;
									end
								endcase
							end
						end
						i2csr_pkg::PH_RXBIT: begin
							shift_n = rx_byte;
							if (bit_q == 3'd7) begin
								bit_n   = 3'd0;
								phase_n = i2csr_pkg::PH_RXACK;
								unique case (byte_q)
									3'd0, 3'd3: high_n = rx_byte;
									3'd1: temp_n = {high_q, rx_byte};
									3'd4: hum_n = {high_q, rx_byte};
									default: ;
								endcase
							end else begin
								bit_n = bit_q + 3'd1;
							end
						end
						default: begin
							if (byte_q >= LAST_BYTE) begin
								phase_n = i2csr_pkg::PH_STOP;
							end else begin
								byte_n  = byte_q + 3'd1;
								shift_n = 8'd0;
								phase_n = i2csr_pkg::PH_RXBIT;
							end
						end
					endcase
				end
			end
			i2csr_pkg::PH_WAIT: begin
				delay_n = delay_q - 1'b1;
				if (delay_n == '0) begin
					sub_n   = 2'd0;
					phase_n = i2csr_pkg::PH_RSTART;
				end
			end
			i2csr_pkg::PH_RSTART: begin
				unique case (sub_q)
					2'd0: sub_n = 2'd1;
					2'd1: sub_n = 2'd2;
					default: begin
						sub_n   = 2'd0;
						byte_n  = 3'd3;
						bit_n   = 3'd0;
						shift_n = {device_address, 1'b1};
						phase_n = i2csr_pkg::PH_TXBIT;
					end
				endcase
			end
			i2csr_pkg::PH_STOP: begin
				if (sub_q == 2'd3) begin
					sub_n   = 2'd0;
					phase_n = i2csr_pkg::PH_IDLE;
				end else begin
					sub_n = sub_q + 2'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2csr_pkg::PH_IDLE;
			brk_q   <= 1'b0;
			sub_q   <= 2'd0;
			bit_q   <= 3'd0;
			byte_q  <= 3'd0;
			shift_q <= 8'd0;
			delay_q <= '0;
			temp_q  <= '0;
			hum_q   <= '0;
			high_q  <= 8'd0;
			scl_q   <= 1'b1;
			sdah_q  <= 1'b1;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			brk_q   <= brk_n;
			sub_q   <= sub_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			delay_q <= delay_n;
			temp_q  <= temp_n;
			hum_q   <= hum_n;
			high_q  <= high_n;
			scl_q   <= scl_o;
			sdah_q  <= sdah_o;
			err_q   <= err_n;
		end
	end

	assign res.flags.scl          = scl_o;
	assign res.flags.sda_pull_low = !sdah_o;
	assign res.flags.busy         = (phase_n != i2csr_pkg::PH_IDLE);
	assign res.flags.done         = done_o;
	assign res.flags.nack_error   = err_n;
	assign res.temp_raw           = temp_n;
	assign res.hum_raw            = hum_n;

endmodule

// ===== rtl/core/i2csr_conv.sv =====
// raw-to-centi conversion, two stages: scale multiply, then divide by 65535 with offset
// depends on i2csr_pkg for widths and scale constants

module i2csr_conv (
	input  logic                                clk,
	input  logic                                en_s3,
	input  logic                                en_s4,
	input  logic [i2csr_pkg::RAW_W-1:0]         temp_raw,
	input  logic [i2csr_pkg::RAW_W-1:0]         hum_raw,
	output logic signed [i2csr_pkg::TEMP_W-1:0] temperature_centi,
	output logic [i2csr_pkg::HUM_W-1:0]         humidity_centi
);

	localparam int TQ_W = i2csr_pkg::TEMP_PROD_W - 16;
	localparam int HQ_W = i2csr_pkg::HUM_PROD_W - 16;

	logic [i2csr_pkg::TEMP_PROD_W-1:0] temp_prod_s3;
	logic [i2csr_pkg::HUM_PROD_W-1:0]  hum_prod_s3;

	logic [TQ_W-1:0] tq0, tq;
	logic [HQ_W-1:0] hq0, hq;
	logic [16:0]     tr0, hr0;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			temp_prod_s3 <= i2csr_pkg::TEMP_PROD_W'(temp_raw) *
				i2csr_pkg::TEMP_PROD_W'(i2csr_pkg::TEMP_SCALE);
			hum_prod_s3  <= i2csr_pkg::HUM_PROD_W'(hum_raw) *
				i2csr_pkg::HUM_PROD_W'(i2csr_pkg::HUM_SCALE);
		end
	end

	// x / 65535: quotient estimate x >> 16 is short by at most one
	assign tq0 = temp_prod_s3[i2csr_pkg::TEMP_PROD_W-1:16];
	assign tr0 = 17'(temp_prod_s3[15:0]) + 17'(tq0);
	assign tq  = tq0 + TQ_W'(tr0 >= 17'hFFFF);

	assign hq0 = hum_prod_s3[i2csr_pkg::HUM_PROD_W-1:16];
	assign hr0 = 17'(hum_prod_s3[15:0]) + 17'(hq0);
	assign hq  = hq0 + HQ_W'(hr0 >= 17'hFFFF);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			temperature_centi <= i2csr_pkg::TEMP_W'(tq) -
				i2csr_pkg::TEMP_W'(i2csr_pkg::TEMP_OFFSET);
			humidity_centi    <= hq;
		end
	end

endmodule

// ===== rtl/core/i2c_sensor_measurement_reader.sv =====
// top level of the i2c sensor measurement reader: tick register, bus engine, conversion
// depends on i2csr_pkg, i2csr_if, i2csr_engine and i2csr_conv

// Each tick transaction is one bus time step of an i2c master that reads a
// temperature/humidity sensor; every tick yields exactly one result transaction with the
// scl level, the sda pull-down, busy/done/nack flags and the last readings in centi-units.
// Kind 1 starts a measurement read (address+write, 16-bit command, wait_ticks idle ticks,
// repeated start, address+read, READ_BYTES bytes, stop); kind 2 sends the break command
// 0x3093 to address 0x44; starts are ignored while busy. A tick is taken every clock
// unless results stall; the engine steps once per tick and the readings pass a two-stage
// multiply/divide conversion through four registers (input, engine, multiply, output).
// Each stage moves on as soon as the stage after it is free, so ticks keep flowing while
// a result waits until all stages fill. Registers must be written through
// cfg_we/cfg_index/cfg_wdata only while no tick is in flight; the block does not check.

module i2c_sensor_measurement_reader #(
	parameter int READ_BYTES = i2csr_pkg::READ_BYTES_DEF,
	parameter int WAIT_WIDTH = i2csr_pkg::WAIT_WIDTH_DEF,
	localparam int CFG_W = (WAIT_WIDTH > i2csr_pkg::CMD_W) ? WAIT_WIDTH : i2csr_pkg::CMD_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	i2csr_tick_if.sink                        tick,
	i2csr_result_if.source                    result,
	input  logic                              cfg_we,
	input  logic [i2csr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]                  cfg_wdata
);

	// configuration registers
	logic [i2csr_pkg::ADDR_W-1:0] device_address_q;
	logic [i2csr_pkg::CMD_W-1:0]  measure_command_q;
	logic [WAIT_WIDTH-1:0]        wait_ticks_q;

	// pipeline valid bits and stage enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic step;

	// tick register
	logic [i2csr_pkg::KIND_W-1:0] kind_s1;
	logic                         sda_s1;

	// engine result and flag pipeline
	i2csr_pkg::step_t  eng_res;
	i2csr_pkg::flags_t flags_s2, flags_s3, flags_s4;
	logic [i2csr_pkg::RAW_W-1:0] temp_raw_s2, hum_raw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q  <= i2csr_pkg::RESET_DEVICE_ADDRESS;
			measure_command_q <= i2csr_pkg::RESET_MEASURE_COMMAND;
			wait_ticks_q      <= WAIT_WIDTH'(i2csr_pkg::RESET_WAIT_TICKS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2csr_pkg::REG_DEVICE_ADDRESS:  device_address_q  <= cfg_wdata[i2csr_pkg::ADDR_W-1:0];
				i2csr_pkg::REG_MEASURE_COMMAND: measure_command_q <= cfg_wdata[i2csr_pkg::CMD_W-1:0];
				i2csr_pkg::REG_WAIT_TICKS:      wait_ticks_q      <= cfg_wdata[WAIT_WIDTH-1:0];
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on this cycle
	assign en_s4 = !v_s4 || result.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign tick.ready = en_s1;

	// the engine commits one tick when it moves from the tick register to stage 2
	assign step = v_s1 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= tick.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= tick.kind;
			sda_s1  <= tick.sda_in;
		end
	end

	i2csr_engine #(
		.READ_BYTES (READ_BYTES),
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.kind            (kind_s1),
		.sda_in          (sda_s1),
		.device_address  (device_address_q),
		.measure_command (measure_command_q),
		.wait_ticks      (wait_ticks_q),
		.res             (eng_res)
	);

	// engine output register, then flags ride alongside the conversion
	always_ff @(posedge clk) begin
		if (en_s2) begin
			flags_s2    <= eng_res.flags;
			temp_raw_s2 <= eng_res.temp_raw;
			hum_raw_s2  <= eng_res.hum_raw;
		end
		if (en_s3) flags_s3 <= flags_s2;
		if (en_s4) flags_s4 <= flags_s3;
	end

	i2csr_conv u_conv (
		.clk               (clk),
		.en_s3             (en_s3),
		.en_s4             (en_s4),
		.temp_raw          (temp_raw_s2),
		.hum_raw           (hum_raw_s2),
		.temperature_centi (result.temperature_centi),
		.humidity_centi    (result.humidity_centi)
	);

	assign result.valid        = v_s4;
	assign result.scl          = flags_s4.scl;
	assign result.sda_pull_low = flags_s4.sda_pull_low;
	assign result.busy_res     = flags_s4.busy;
	assign result.done_res     = flags_s4.done;
	assign result.nack_error   = flags_s4.nack_error;

endmodule

// ===== rtl/core/i2csr_checker.sv =====
// port-level checks for the i2c sensor measurement reader, attached by bind
// depends on i2csr_pkg for reading limits

module i2csr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                valid,
	input logic                                ready,
	input logic                                scl,
	input logic                                sda_pull_low,
	input logic                                busy_res,
	input logic                                done_res,
	input logic signed [i2csr_pkg::TEMP_W-1:0] temperature_centi,
	input logic [i2csr_pkg::HUM_W-1:0]         humidity_centi
);

	// the tick that ends a transaction leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> !busy_res)
		else $error("done result still busy");

	// stop ends with scl high and sda released
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> scl && !sda_pull_low)
		else $error("done result with bus not released");

	// readings stay within the sensor range
	a_reading_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> humidity_centi <= i2csr_pkg::HUM_SCALE &&
			temperature_centi >= -i2csr_pkg::TEMP_OFFSET &&
			temperature_centi <= i2csr_pkg::TEMP_SCALE - i2csr_pkg::TEMP_OFFSET)
		else $error("reading out of range");

	// a result that waits keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(scl) && $stable(sda_pull_low) &&
			$stable(done_res) && $stable(temperature_centi))
		else $error("waiting result changed");

endmodule

bind i2c_sensor_measurement_reader i2csr_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.valid             (result.valid),
	.ready             (result.ready),
	.scl               (result.scl),
	.sda_pull_low      (result.sda_pull_low),
	.busy_res          (result.busy_res),
	.done_res          (result.done_res),
	.temperature_centi (result.temperature_centi),
	.humidity_centi    (result.humidity_centi)
);

// ===== tb/i2c_sensor_measurement_reader_test.sv =====
// testbench for the i2c sensor measurement reader: directed table, then random bus traffic
// depends on i2csr_pkg, the tick/result interfaces and the i2c_sensor_measurement_reader top

module i2c_sensor_measurement_reader_test;
	import i2csr_pkg::*;

	localparam int CFG_W = (WAIT_WIDTH_DEF > CMD_W) ? WAIT_WIDTH_DEF : CMD_W;
	localparam int READ_BYTES = READ_BYTES_DEF;
	localparam int FULL_SCALE = 65535;
	localparam int HOLD_CYCLES = 150;   // long receiver stall, fills the pipeline
	localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either channel
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// everything one tick puts on the result channel
	typedef struct packed {
		logic                     scl;
		logic                     pull;
		logic                     busy;
		logic                     done;
		logic                     err;
		logic signed [TEMP_W-1:0] temp_c;
		logic [HUM_W-1:0]         hum_c;
	} tick_out_t;

	// one line of the directed table: a tick repeated reps times
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              sda;
		logic [5:0]        reps;
		logic              typed;
		tick_out_t         want;
	} drill_row_t;

	// results that can be read straight off the spec with raw readings still zero
	localparam tick_out_t IDLE_AT_RESET = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, -15'sd4500, 14'd0};
	localparam tick_out_t START_AT_RESET = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, -15'sd4500, 14'd0};
	localparam tick_out_t NACK_DONE = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, -15'sd4500, 14'd0};
	localparam tick_out_t UNTYPED = '0;

	// directed part: idle lines, unused kind, starts while busy, missing acknowledge on the
	// address byte, stop with the error flag, then a break start that clears the flag
	localparam drill_row_t DRILL [12] = '{
		'{KIND_TICK,    1'b0, 6'd1,  1'b1, IDLE_AT_RESET},
		'{KIND_TICK,    1'b1, 6'd1,  1'b1, IDLE_AT_RESET},
		'{KIND_UNUSED,  1'b1, 6'd1,  1'b1, IDLE_AT_RESET},
		'{KIND_MEASURE, 1'b0, 6'd1,  1'b1, START_AT_RESET},
		'{KIND_BREAK,   1'b1, 6'd1,  1'b0, UNTYPED},        // start ignored while busy
		'{KIND_MEASURE, 1'b0, 6'd1,  1'b0, UNTYPED},        // same, other mode
		'{KIND_UNUSED,  1'b0, 6'd22, 1'b0, UNTYPED},        // rest of the address bits
		'{KIND_TICK,    1'b1, 6'd2,  1'b0, UNTYPED},        // acknowledge bit, low scl
		'{KIND_TICK,    1'b1, 6'd1,  1'b0, UNTYPED},        // sampled high: no acknowledge
		'{KIND_TICK,    1'b0, 6'd3,  1'b0, UNTYPED},        // stop condition
		'{KIND_TICK,    1'b0, 6'd1,  1'b1, NACK_DONE},
		'{KIND_BREAK,   1'b0, 6'd1,  1'b1, START_AT_RESET}  // new start clears the error
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	i2csr_tick_if   tick_ch ();
	i2csr_result_if res_ch ();

	i2c_sensor_measurement_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// master model state, starting from its reset values
	phase_t      m_phase = PH_IDLE;
	logic        m_brk = 1'b0;
	logic [1:0]  m_sub = '0;
	logic [2:0]  m_bit = '0;
	logic [2:0]  m_byte = '0;
	logic [7:0]  m_shift = '0;
	logic [19:0] m_delay = '0;
	logic [15:0] m_temp_raw = '0;
	logic [15:0] m_hum_raw = '0;
	logic [7:0]  m_high = '0;
	logic        m_scl = 1'b1;
	logic        m_sda = 1'b1;
	logic        m_err = 1'b0;

	// register copies
	logic [ADDR_W-1:0] r_addr = RESET_DEVICE_ADDRESS;
	logic [CMD_W-1:0]  r_cmd = RESET_MEASURE_COMMAND;
	logic [19:0]       r_wait = 20'(RESET_WAIT_TICKS);

	tick_out_t line_states_due [$];

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  hold_request = 1'b0;
	int  mismatches = 0;
	int  ticks_sent = 0;
	int  results_checked = 0;
	int  transactions_done = 0;
	int  nack_aborts = 0;
	int  settings_used = 1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- master model

	function automatic void load_byte(input logic [7:0] b);
		m_shift = b;
		m_bit = '0;
		m_phase = PH_TXBIT;
	endfunction

	// one bus time step (tick) of the master: returns line levels, flags and readings
	function automatic tick_out_t advance_master(input logic [KIND_W-1:0] k, input logic s);
		tick_out_t   o;
		logic        scl_o;
		logic        sdah_o;
		logic        done;
		logic        bit_end;
		logic        v;
		logic [31:0] t_wide;
		logic [31:0] h_wide;

		scl_o = m_scl;
		sdah_o = m_sda;
		done = 1'b0;
		case (m_phase)
			PH_IDLE: begin
				scl_o = 1'b1;
				sdah_o = 1'b1;
				if (k == KIND_MEASURE || k == KIND_BREAK) begin
					m_brk = (k == KIND_BREAK);
					m_err = 1'b0;
					m_byte = '0;
					m_sub = '0;
					sdah_o = 1'b0;  // start condition
					load_byte(m_brk ? {BREAK_ADDR, 1'b0} : {r_addr, 1'b0});
				end
			end
			PH_TXBIT, PH_TXACK, PH_RXBIT, PH_RXACK: begin
				bit_end = (m_sub >= 2);
				if (m_sub == 0) begin
					scl_o = 1'b0;
				end else begin
					v = 1'b1;
					if (m_phase == PH_TXBIT)
						v = m_shift[7];
					else if (m_phase == PH_RXACK)
						v = (m_byte + 1 >= READ_BYTES);  // nack only the last byte
					scl_o = bit_end;
					sdah_o = v;
				end
				if (!bit_end) begin
					m_sub++;
				end else begin
					m_sub = '0;
					if (m_phase == PH_TXBIT) begin
						m_shift = m_shift << 1;
						if (m_bit >= 7) begin
							m_bit = '0;
							m_phase = PH_TXACK;
						end else
							m_bit++;
					end else if (m_phase == PH_TXACK) begin
						if (s) begin
							m_err = 1'b1;
							m_phase = PH_STOP;
						end else begin
							case (m_byte)
								3'd0: begin
									m_byte = 3'd1;
									load_byte(m_brk ? BREAK_CMD[15:8] : r_cmd[15:8]);
								end
								3'd1: begin
									m_byte = 3'd2;
									load_byte(m_brk ? BREAK_CMD[7:0] : r_cmd[7:0]);
								end
								3'd2: begin
									if (m_brk) begin
										m_phase = PH_STOP;
									end else begin
										m_delay = r_wait;
										m_phase = (m_delay == 0) ? PH_RSTART : PH_WAIT;
									end
								end
								default: begin  // read address acknowledged
									m_byte = '0;
									m_bit = '0;
									m_shift = '0;
									m_phase = PH_RXBIT;
								end
							endcase
						end
					end else if (m_phase == PH_RXBIT) begin
						m_shift = {m_shift[6:0], s};
						if (m_bit >= 7) begin
							m_bit = '0;
							case (m_byte)
								3'd0, 3'd3: m_high = m_shift;
								3'd1: m_temp_raw = {m_high, m_shift};
								3'd4: m_hum_raw = {m_high, m_shift};
								default: ;  // crc bytes
							endcase
							m_phase = PH_RXACK;
						end else
							m_bit++;
					end else begin
						if (m_byte + 1 >= READ_BYTES) begin
							m_phase = PH_STOP;
						end else begin
							m_byte++;
							m_shift = '0;
							m_phase = PH_RXBIT;
						end
					end
				end
			end
			PH_WAIT: begin
				scl_o = 1'b0;
				sdah_o = 1'b1;
				m_delay = m_delay - 20'd1;
				if (m_delay == 0) begin
					m_sub = '0;
					m_phase = PH_RSTART;
				end
			end
			PH_RSTART: begin
				if (m_sub == 0) begin
					scl_o = 1'b0;
					sdah_o = 1'b1;
					m_sub = 2'd1;
				end else if (m_sub == 1) begin
					scl_o = 1'b1;
					sdah_o = 1'b1;
					m_sub = 2'd2;
				end else begin
					scl_o = 1'b1;
					sdah_o = 1'b0;
					m_sub = '0;
					m_byte = 3'd3;
					load_byte({r_addr, 1'b1});
				end
			end
			default: begin  // stop
				if (m_sub == 0) begin
					scl_o = 1'b0;
					m_sub = 2'd1;
				end else if (m_sub == 1) begin
					scl_o = 1'b0;
					sdah_o = 1'b0;
					m_sub = 2'd2;
				end else if (m_sub == 2) begin
					scl_o = 1'b1;
					sdah_o = 1'b0;
					m_sub = 2'd3;
				end else begin
					scl_o = 1'b1;
					sdah_o = 1'b1;
					m_sub = '0;
					done = 1'b1;
					m_phase = PH_IDLE;
				end
			end
		endcase

		m_scl = scl_o;
		m_sda = sdah_o;

		// centi-unit conversion, wrapping in 32 bits before the cut to port width
		t_wide = 32'(m_temp_raw);
		t_wide = t_wide * TEMP_SCALE / FULL_SCALE - TEMP_OFFSET;
		h_wide = 32'(m_hum_raw);
		h_wide = h_wide * HUM_SCALE / FULL_SCALE;

		o.scl = scl_o;
		o.pull = ~sdah_o;
		o.busy = (m_phase != PH_IDLE);
		o.done = done;
		o.err = m_err;
		o.temp_c = t_wide[TEMP_W-1:0];
		o.hum_c = h_wide[HUM_W-1:0];
		return o;
	endfunction

	// ---------------------------------------------------------------- tick sender

	// offer one tick, wait for its transaction, then log what it must produce
	task automatic send_tick(input logic [KIND_W-1:0] k, input logic s, input bit typed,
		input tick_out_t typed_want);
		tick_out_t predicted;

		while ($urandom_range(99) < tx_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.kind <= k;
		tick_ch.sda_in <= s;
		do @(posedge clk); while (!tick_ch.ready);
		predicted = advance_master(k, s);
		line_states_due.push_back(typed ? typed_want : predicted);
		ticks_sent++;
	endtask

	// sender goes quiet until every logged result has come back
	task automatic wait_for_results();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (line_states_due.size() != 0);
	endtask

	// random ticks shaped like a cooperating sensor; always ends with the bus idle
	task automatic run_ticks(input int count, input bit abort_before_wait, input bit squeeze);
		int                sent;
		int                r;
		logic [KIND_W-1:0] k;
		logic              s;

		sent = 0;
		while (sent < count || m_phase != PH_IDLE) begin
			if (squeeze && sent == count / 2)
				hold_request = 1'b1;  // receiver stalls, sender keeps offering
			if (squeeze && sent == 3 * count / 4)
				wait_for_results();

			r = $urandom_range(99);
			if (m_phase == PH_IDLE)
				k = (r < 55) ? KIND_MEASURE : (r < 80) ? KIND_BREAK :
					(r < 90) ? KIND_TICK : KIND_UNUSED;
			else
				k = (r < 96) ? KIND_TICK : KIND_W'($urandom_range(3, 1));

			// acknowledge sample: mostly ack, a few aborts; forced abort before a long wait
			if (m_phase == PH_TXACK && m_sub == 2)
				s = (abort_before_wait && !m_brk && m_byte == 2) || ($urandom_range(99) < 3);
			else
				s = 1'($urandom_range(1));

			send_tick(k, s, 1'b0, UNTYPED);
			sent++;
		end
	endtask

	// one register setting: drain, write all three registers, then run traffic
	task automatic run_phase(input logic [ADDR_W-1:0] addr, input logic [CMD_W-1:0] cmd,
		input logic [19:0] wticks, input int tx_pct, input int rx_pct, input int count,
		input bit abort_before_wait, input bit squeeze);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_wdata <= CFG_W'(addr);
		@(posedge clk);
		cfg_index <= REG_MEASURE_COMMAND;
		cfg_wdata <= CFG_W'(cmd);
		@(posedge clk);
		cfg_index <= REG_WAIT_TICKS;
		cfg_wdata <= CFG_W'(wticks);
		@(posedge clk);
		cfg_we <= 1'b0;
		r_addr = addr;
		r_cmd = cmd;
		r_wait = wticks;
		settings_used++;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		run_ticks(count, abort_before_wait, squeeze);
	endtask

	// ---------------------------------------------------------------- result side

	// receiver ready: random stalls, plus one long hold on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else
				res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_checked, what, got, want);
		mismatches++;
	endtask

	// every result transaction is matched against the oldest logged expectation
	always @(posedge clk) begin
		tick_out_t got;
		tick_out_t want;

		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.scl, res_ch.sda_pull_low, res_ch.busy_res, res_ch.done_res,
				res_ch.nack_error, res_ch.temperature_centi, res_ch.humidity_centi};
			if (line_states_due.size() == 0) begin
				flag_mismatch("result with nothing expected, done", got.done, 0);
			end else begin
				want = line_states_due.pop_front();
				if (got.scl !== want.scl) flag_mismatch("scl", got.scl, want.scl);
				if (got.pull !== want.pull) flag_mismatch("sda_pull_low", got.pull, want.pull);
				if (got.busy !== want.busy) flag_mismatch("busy_res", got.busy, want.busy);
				if (got.done !== want.done) flag_mismatch("done_res", got.done, want.done);
				if (got.err !== want.err) flag_mismatch("nack_error", got.err, want.err);
				if (got.temp_c !== want.temp_c)
					flag_mismatch("temperature_centi", $signed(got.temp_c), $signed(want.temp_c));
				if (got.hum_c !== want.hum_c)
					flag_mismatch("humidity_centi", got.hum_c, want.hum_c);
			end
			if (got.done === 1'b1) begin
				transactions_done++;
				if (got.err === 1'b1)
					nack_aborts++;
			end
			results_checked++;
		end
	end

	// watchdog: too long without any transaction on either channel ends the run
	initial begin : watchdog
		int quiet;

		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transaction for %0d cycles, giving up", QUIET_LIMIT);
		$display("i2c_sensor_measurement_reader verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		tick_ch.valid <= 1'b0;
		tick_ch.kind <= KIND_TICK;
		tick_ch.sda_in <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table with reset register values, sender 20% / receiver 68% idle
		tx_idle_pct = 20;
		rx_idle_pct = 68;
		foreach (DRILL[i])
			repeat (DRILL[i].reps)
				send_tick(DRILL[i].kind, DRILL[i].sda, DRILL[i].typed, DRILL[i].want);
		run_ticks(0, 1'b0, 1'b0);  // let the break transaction run out

		// all-zero registers with no wait, then all-ones registers with a one-tick wait
		run_phase(7'h00, 16'h0000, 20'd0, 20, 68, 300, 1'b0, 1'b0);
		run_phase(7'h7F, 16'hFFFF, 20'd1, 20, 68, 300, 1'b0, 1'b0);

		// idling swapped: random registers, then the longest wait with measurements
		// aborted on the command acknowledge so the wait never runs
		run_phase(7'($urandom_range(127)), 16'($urandom), 20'($urandom_range(40, 2)),
			68, 20, 300, 1'b0, 1'b0);
		run_phase(7'($urandom_range(127)), 16'($urandom), 20'hFFFFF, 68, 20, 250, 1'b1, 1'b0);

		// no idling: long receiver hold and a sender pause, then plain random traffic
		run_phase(RESET_DEVICE_ADDRESS, 16'($urandom), 20'($urandom_range(120)),
			0, 0, 300, 1'b0, 1'b1);
		run_phase(7'($urandom_range(127)), 16'($urandom), 20'($urandom_range(8)),
			0, 0, 300, 1'b0, 1'b0);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (line_states_due.size() != 0)
			flag_mismatch("results still expected at the end", 0, line_states_due.size());

		$display("%0d ticks over %0d register settings, %0d results compared",
			ticks_sent, settings_used, results_checked);
		$display("%0d transactions completed, %0d ended by a missing acknowledge",
			transactions_done, nack_aborts);
		if (mismatches == 0)
			$display("i2c_sensor_measurement_reader verification clean");
		else
			$display("i2c_sensor_measurement_reader verification failed");
		$finish;
	end

endmodule
